@@ rtl/mvn_pkg.sv @@
package mvn_pkg;

  localparam int unsigned VERTEX_DEPTH_DEF = 1024;

  localparam int COORD_W  = 16;
  localparam int INDEX_W  = 10;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int SUM_W    = 48;
  localparam int NORM_W   = 16;
  localparam int MAG_W    = 30;
  localparam int SQ_W     = 2 * MAG_W + 2;
  localparam int ROOT_W   = 32;
  localparam int FRAC_W   = 14;
  localparam int QUO_W    = FRAC_W + 1;
  localparam int DIV_W    = ROOT_W + QUO_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FACE  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [INDEX_W-1:0]        index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [INDEX_W-1:0]        corner_a;
    logic [INDEX_W-1:0]        corner_b;
    logic [INDEX_W-1:0]        corner_c;
  } in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     no_faces;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum_vec_t;

  typedef struct packed {
    logic     used;
    sum_vec_t sum;
  } sum_entry_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } normal_t;

  typedef struct packed {
    logic busy;
    logic done;
  } norm_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRD,
    S_DIFF,
    S_MUL,
    S_ACC_RD,
    S_ACC_WR,
    S_R_RD,
    S_R_LD,
    S_R_WAIT,
    S_R_OUT
  } top_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIVINIT,
    N_DIV,
    N_DONE
  } norm_state_e;

endpackage

@@ rtl/mvn_if.sv @@
interface mvn_in_if;
  logic         valid;
  logic         ready;
  mvn_pkg::in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mvn_out_if;
  logic          valid;
  logic          ready;
  mvn_pkg::out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/mesh_vertex_normals_top.sv @@
// Per-vertex normal accumulator for a triangle mesh.
// in_i carries one transaction per operation: write vertex (position and
// clear of its sum), add face (corners a, b, c) or read normal (index).
// out_o carries one transaction per read: unit normal in Q1.14 plus the
// no_faces flag. Writes and face adds produce nothing on out_o.
// A write is done in the idle state. A face add reads the three corner
// positions, forms the edge differences u and v, builds the cross product on
// the shared 17x17 multiplier and does a sum read-modify-write for each
// distinct corner, a repeated corner getting only the read. A read fetches
// the sum and, if used, runs the normalizer: a range check with shifts to
// bring the largest magnitude into range, squaring, a square root, a divide
// per component and a done state; the root and divide are bit-serial.
// One operation is in work at a time; in_i.ready is high in the idle state.
// The result sits in an output register, so a stalled receiver only holds
// a read at its last step while writes and face adds go on.
// Reset clears control state only; vertex memories hold nothing defined
// until written.
module mesh_vertex_normals_top #(
  parameter int unsigned VERTEX_DEPTH = mvn_pkg::VERTEX_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mvn_in_if.sink         in_i,
  mvn_out_if.source      out_o
);

  localparam int unsigned AW = $clog2(VERTEX_DEPTH);
  localparam int DIFF_W  = mvn_pkg::DIFF_W;
  localparam int PROD_W  = mvn_pkg::PROD_W;
  localparam int CROSS_W = mvn_pkg::CROSS_W;
  localparam int SUM_W   = mvn_pkg::SUM_W;
  localparam int INDEX_W = mvn_pkg::INDEX_W;

  function automatic logic in_range(logic [INDEX_W-1:0] idx);
    return 32'(idx) < VERTEX_DEPTH;
  endfunction

  function automatic logic [AW-1:0] to_addr(logic [INDEX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[AW-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] s,
                                                      logic signed [CROSS_W-1:0] d);
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(s) + (SUM_W+1)'(d);
    if (r[SUM_W] != r[SUM_W-1]) begin
      return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r[SUM_W-1:0];
  endfunction

  mvn_pkg::top_state_e state_q, state_d;

  mvn_pkg::in_t  item_q, item_d;
  mvn_pkg::pos_t pos_q [3];
  mvn_pkg::pos_t pos_d [3];
  logic signed [DIFF_W-1:0]  u_q [3];
  logic signed [DIFF_W-1:0]  u_d [3];
  logic signed [DIFF_W-1:0]  v_q [3];
  logic signed [DIFF_W-1:0]  v_d [3];
  logic signed [CROSS_W-1:0] cr_q [3];
  logic signed [CROSS_W-1:0] cr_d [3];
  logic [2:0] j_q, j_d;
  logic [1:0] k_q, k_d;
  logic       none_q, none_d;
  mvn_pkg::out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic                     in_acc;
  logic                     load_out;
  logic                     pos_we;
  logic [AW-1:0]            pos_addr;
  mvn_pkg::pos_t            pos_wdata;
  mvn_pkg::pos_t            pos_rdata;
  logic                     sum_we;
  logic [AW-1:0]            sum_addr;
  mvn_pkg::sum_entry_t      sum_wdata;
  mvn_pkg::sum_entry_t      sum_rdata;
  logic                     norm_start;
  mvn_pkg::norm_status_t    norm_status;
  mvn_pkg::normal_t         norm_res;
  logic [INDEX_W-1:0]       corner;
  logic                     distinct;
  logic                     face_ok;
  logic signed [DIFF_W-1:0] opa, opb;
  logic signed [PROD_W-1:0] prod;

  assign in_i.ready = state_q == mvn_pkg::S_IDLE;
  assign in_acc     = in_i.valid && in_i.ready;
  assign face_ok    = in_range(in_i.payload.corner_a) && in_range(in_i.payload.corner_b)
                   && in_range(in_i.payload.corner_c);

  always_comb begin
    case (k_q)
      2'd0:    corner = item_q.corner_a;
      2'd1:    corner = item_q.corner_b;
      default: corner = item_q.corner_c;
    endcase
    case (k_q)
      2'd0:    distinct = 1'b1;
      2'd1:    distinct = item_q.corner_b != item_q.corner_a;
      default: distinct = (item_q.corner_c != item_q.corner_a)
                       && (item_q.corner_c != item_q.corner_b);
    endcase
  end

  always_comb begin
    case (j_q)
      3'd0:    begin opa = u_q[1]; opb = v_q[2]; end
      3'd1:    begin opa = u_q[2]; opb = v_q[1]; end
      3'd2:    begin opa = u_q[2]; opb = v_q[0]; end
      3'd3:    begin opa = u_q[0]; opb = v_q[2]; end
      3'd4:    begin opa = u_q[0]; opb = v_q[1]; end
      default: begin opa = u_q[1]; opb = v_q[0]; end
    endcase
  end

  assign prod = opa * opb;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    pos_d       = pos_q;
    u_d         = u_q;
    v_d         = v_q;
    cr_d        = cr_q;
    j_d         = j_q;
    k_d         = k_q;
    none_d      = none_q;
    out_d       = out_q;
    load_out    = 1'b0;
    pos_we      = 1'b0;
    pos_addr    = to_addr(in_i.payload.index);
    pos_wdata.x = in_i.payload.coord_x;
    pos_wdata.y = in_i.payload.coord_y;
    pos_wdata.z = in_i.payload.coord_z;
    sum_we      = 1'b0;
    sum_addr    = to_addr(in_i.payload.index);
    sum_wdata   = '0;
    norm_start  = 1'b0;
    unique case (state_q)
      mvn_pkg::S_IDLE: begin
        if (in_acc) begin
          item_d = in_i.payload;
          unique case (in_i.payload.operation)
            mvn_pkg::OP_WRITE: begin
              if (in_range(in_i.payload.index)) begin
                pos_we = 1'b1;
                sum_we = 1'b1;
              end
            end
            mvn_pkg::OP_FACE: begin
              if (face_ok) begin
                k_d     = '0;
                state_d = mvn_pkg::S_PRD;
              end
            end
            mvn_pkg::OP_READ: begin
              if (in_range(in_i.payload.index)) begin
                state_d = mvn_pkg::S_R_RD;
              end else begin
                none_d  = 1'b1;
                state_d = mvn_pkg::S_R_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      mvn_pkg::S_PRD: begin
        pos_addr = to_addr(corner);
        if (k_q != 2'd0) pos_d[k_q - 2'd1] = pos_rdata;
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) state_d = mvn_pkg::S_DIFF;
      end
      mvn_pkg::S_DIFF: begin
        u_d[0] = DIFF_W'(pos_q[0].x) - DIFF_W'(pos_q[2].x);
        u_d[1] = DIFF_W'(pos_q[0].y) - DIFF_W'(pos_q[2].y);
        u_d[2] = DIFF_W'(pos_q[0].z) - DIFF_W'(pos_q[2].z);
        v_d[0] = DIFF_W'(pos_q[2].x) - DIFF_W'(pos_q[1].x);
        v_d[1] = DIFF_W'(pos_q[2].y) - DIFF_W'(pos_q[1].y);
        v_d[2] = DIFF_W'(pos_q[2].z) - DIFF_W'(pos_q[1].z);
        j_d     = '0;
        state_d = mvn_pkg::S_MUL;
      end
      mvn_pkg::S_MUL: begin
        if (!j_q[0]) cr_d[j_q[2:1]] = CROSS_W'(prod);
        else         cr_d[j_q[2:1]] = cr_q[j_q[2:1]] - CROSS_W'(prod);
        j_d = j_q + 3'd1;
        if (j_q == 3'd5) begin
          k_d     = '0;
          state_d = mvn_pkg::S_ACC_RD;
        end
      end
      mvn_pkg::S_ACC_RD: begin
        sum_addr = to_addr(corner);
        if (distinct) begin
          state_d = mvn_pkg::S_ACC_WR;
        end else if (k_q == 2'd2) begin
          state_d = mvn_pkg::S_IDLE;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      mvn_pkg::S_ACC_WR: begin
        sum_addr        = to_addr(corner);
        sum_we          = 1'b1;
        sum_wdata.used  = 1'b1;
        sum_wdata.sum.x = sat_add(sum_rdata.sum.x, cr_q[0]);
        sum_wdata.sum.y = sat_add(sum_rdata.sum.y, cr_q[1]);
        sum_wdata.sum.z = sat_add(sum_rdata.sum.z, cr_q[2]);
        k_d             = k_q + 2'd1;
        state_d         = (k_q == 2'd2) ? mvn_pkg::S_IDLE : mvn_pkg::S_ACC_RD;
      end
      mvn_pkg::S_R_RD: begin
        sum_addr = to_addr(item_q.index);
        state_d  = mvn_pkg::S_R_LD;
      end
      mvn_pkg::S_R_LD: begin
        if (!sum_rdata.used) begin
          none_d  = 1'b1;
          state_d = mvn_pkg::S_R_OUT;
        end else begin
          none_d     = 1'b0;
          norm_start = 1'b1;
          state_d    = mvn_pkg::S_R_WAIT;
        end
      end
      mvn_pkg::S_R_WAIT: begin
        if (norm_status.done) state_d = mvn_pkg::S_R_OUT;
      end
      mvn_pkg::S_R_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          if (none_q) begin
            out_d = '{normal_x: '0, normal_y: '0, normal_z: '0, no_faces: 1'b1};
          end else begin
            out_d = '{normal_x: norm_res.x, normal_y: norm_res.y,
                      normal_z: norm_res.z, no_faces: 1'b0};
          end
          state_d = mvn_pkg::S_IDLE;
        end
      end
      default: state_d = mvn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvn_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pos_q  <= pos_d;
    u_q    <= u_d;
    v_q    <= v_d;
    cr_q   <= cr_d;
    j_q    <= j_d;
    k_q    <= k_d;
    none_q <= none_d;
    out_q  <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  mvn_ram #(
    .WIDTH ($bits(mvn_pkg::pos_t)),
    .DEPTH (VERTEX_DEPTH)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .addr_i  (pos_addr),
    .wdata_i (pos_wdata),
    .rdata_o (pos_rdata)
  );

  mvn_ram #(
    .WIDTH ($bits(mvn_pkg::sum_entry_t)),
    .DEPTH (VERTEX_DEPTH)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .addr_i  (sum_addr),
    .wdata_i (sum_wdata),
    .rdata_o (sum_rdata)
  );

  mvn_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (norm_start),
    .sum_i    (sum_rdata.sum),
    .status_o (norm_status),
    .normal_o (norm_res)
  );

  a_norm_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_status.done |-> state_q == mvn_pkg::S_R_WAIT)
    else $error("normalizer finished outside a read");

  a_norm_busy_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_status.busy |-> state_q == mvn_pkg::S_R_WAIT)
    else $error("normalizer busy outside a read");

  a_sum_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_we |-> (state_q == mvn_pkg::S_IDLE || state_q == mvn_pkg::S_ACC_WR))
    else $error("sum memory written outside write or accumulate");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_o.valid)
    else $error("loaded result not presented");

  a_bad_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.payload.operation == mvn_pkg::OP_FACE && !face_ok)
      |=> state_q == mvn_pkg::S_IDLE)
    else $error("out of range face was processed");

endmodule

@@ rtl/mvn_ram.sv @@
module mvn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mvn_norm.sv @@
module mvn_norm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  mvn_pkg::sum_vec_t     sum_i,
  output mvn_pkg::norm_status_t status_o,
  output mvn_pkg::normal_t      normal_o
);

  localparam int SUM_W  = mvn_pkg::SUM_W;
  localparam int MAG_W  = mvn_pkg::MAG_W;
  localparam int SQ_W   = mvn_pkg::SQ_W;
  localparam int ROOT_W = mvn_pkg::ROOT_W;
  localparam int FRAC_W = mvn_pkg::FRAC_W;
  localparam int QUO_W  = mvn_pkg::QUO_W;
  localparam int DIV_W  = mvn_pkg::DIV_W;
  localparam int NORM_W = mvn_pkg::NORM_W;

  mvn_pkg::norm_state_e state_q, state_d;

  logic [SUM_W-1:0]  m_q [3];
  logic [SUM_W-1:0]  m_d [3];
  logic              pos_q [3];
  logic              pos_d [3];
  logic [NORM_W-1:0] res_q [3];
  logic [NORM_W-1:0] res_d [3];
  logic [SQ_W-1:0]   acc_q, acc_d;
  logic [SQ_W:0]     root_q, root_d;
  logic [SQ_W:0]     bit_q, bit_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [3:0]        step_q, step_d;
  logic [1:0]        k_q, k_d;

  logic [SUM_W-1:0]   mx;
  logic [2*MAG_W-1:0] sq;
  logic [SQ_W:0]      trial;
  logic               ge;
  logic [NORM_W-1:0]  qext;

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
  end

  assign sq    = m_q[k_q][MAG_W-1:0] * m_q[k_q][MAG_W-1:0];
  assign trial = root_q + bit_q;
  assign ge    = rem_q >= div_q;

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    pos_d   = pos_q;
    res_d   = res_q;
    acc_d   = acc_q;
    root_d  = root_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    step_d  = step_q;
    k_d     = k_q;
    qext    = '0;
    unique case (state_q)
      mvn_pkg::N_IDLE: begin
        if (start_i) begin
          m_d[0]  = sum_i.x[SUM_W-1] ? SUM_W'(-sum_i.x) : SUM_W'(sum_i.x);
          m_d[1]  = sum_i.y[SUM_W-1] ? SUM_W'(-sum_i.y) : SUM_W'(sum_i.y);
          m_d[2]  = sum_i.z[SUM_W-1] ? SUM_W'(-sum_i.z) : SUM_W'(sum_i.z);
          pos_d[0] = !sum_i.x[SUM_W-1] && (sum_i.x != '0);
          pos_d[1] = !sum_i.y[SUM_W-1] && (sum_i.y != '0);
          pos_d[2] = !sum_i.z[SUM_W-1] && (sum_i.z != '0);
          state_d = mvn_pkg::N_SHIFT;
        end
      end
      mvn_pkg::N_SHIFT: begin
        if (mx == '0) begin
          for (int i = 0; i < 3; i++) res_d[i] = '0;
          state_d = mvn_pkg::N_DONE;
        end else if (mx[SUM_W-1:MAG_W] != '0) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (mx[SUM_W-1:MAG_W-1] == '0) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          acc_d   = '0;
          k_d     = '0;
          state_d = mvn_pkg::N_SQ;
        end
      end
      mvn_pkg::N_SQ: begin
        acc_d = acc_q + SQ_W'(sq);
        k_d   = k_q + 2'd1;
        if (k_q == 2'd2) begin
          root_d  = '0;
          bit_d   = (SQ_W+1)'(1) << SQ_W;
          state_d = mvn_pkg::N_SQRT;
        end
      end
      mvn_pkg::N_SQRT: begin
        if ({1'b0, acc_q} >= trial) begin
          acc_d  = acc_q - trial[SQ_W-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          k_d     = '0;
          state_d = mvn_pkg::N_DIVINIT;
        end
      end
      mvn_pkg::N_DIVINIT: begin
        rem_d   = DIV_W'({m_q[k_q][MAG_W-1:0], FRAC_W'(0)})
                + DIV_W'(root_q[ROOT_W-1:1]);
        div_d   = DIV_W'({root_q[ROOT_W-1:0], FRAC_W'(0)});
        quo_d   = '0;
        step_d  = '0;
        state_d = mvn_pkg::N_DIV;
      end
      mvn_pkg::N_DIV: begin
        if (ge) rem_d = rem_q - div_q;
        div_d  = div_q >> 1;
        quo_d  = {quo_q[QUO_W-2:0], ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'(QUO_W - 1)) begin
          qext       = {1'b0, quo_d};
          res_d[k_q] = pos_q[k_q] ? -qext : qext;
          k_d        = k_q + 2'd1;
          state_d    = (k_q == 2'd2) ? mvn_pkg::N_DONE : mvn_pkg::N_DIVINIT;
        end
      end
      mvn_pkg::N_DONE: begin
        state_d = mvn_pkg::N_IDLE;
      end
      default: state_d = mvn_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvn_pkg::N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    pos_q  <= pos_d;
    res_q  <= res_d;
    acc_q  <= acc_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    k_q    <= k_d;
  end

  assign status_o.busy = state_q != mvn_pkg::N_IDLE;
  assign status_o.done = state_q == mvn_pkg::N_DONE;
  assign normal_o.x    = res_q[0];
  assign normal_o.y    = res_q[1];
  assign normal_o.z    = res_q[2];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == mvn_pkg::N_IDLE)
    else $error("normalizer started while busy");

  a_sqrt_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mvn_pkg::N_SQRT && bit_q[0]) |=> state_q == mvn_pkg::N_DIVINIT)
    else $error("root iteration did not hand over to divider");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mvn_pkg::N_DIV |-> quo_q[QUO_W-1] == 1'b0)
    else $error("quotient overran unit range");

endmodule

@@ bench/mesh_vertex_normals_top_tb.sv @@
module mesh_vertex_normals_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = mvn_pkg::VERTEX_DEPTH_DEF;
  localparam int IW = mvn_pkg::INDEX_W;
  localparam int CW = mvn_pkg::COORD_W;
  localparam int NW = mvn_pkg::NORM_W;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1860;
  localparam int BIG_FACES = 16;

  typedef struct {
    mvn_pkg::in_t item;
    bit           drain;
    bit           rush;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mvn_in_if  in_i ();
  mvn_out_if out_o ();

  mesh_vertex_normals_top #(.VERTEX_DEPTH(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  always #5 clk_i = ~clk_i;

  stim_t          pending_q[$];
  mvn_pkg::out_t  normals_due_q[$];
  int     errors = 0;
  int     idle_cycles = 0;

  // predictor state
  logic signed [CW-1:0] pos_x[DEPTH], pos_y[DEPTH], pos_z[DEPTH];
  longint sum_x[DEPTH], sum_y[DEPTH], sum_z[DEPTH];
  bit     used[DEPTH];

  // generation-time record of written slots
  bit written[DEPTH];
  int written_q[$];

  function automatic longint sat_sum(longint s, longint d);
    longint r;
    r = s + d;
    if (r > SUM_HI) r = SUM_HI;
    if (r < SUM_LO) r = SUM_LO;
    return r;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic mvn_pkg::out_t unit_normal(longint s[3]);
    longint unsigned m[3], mx, mag, q;
    logic [NW-1:0] res[3];
    mvn_pkg::out_t o;
    for (int k = 0; k < 3; k++) begin
      m[k] = (s[k] < 0) ? longint'(-s[k]) : s[k];
      res[k] = '0;
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx != 0) begin
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int k = 0; k < 3; k++) m[k] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int k = 0; k < 3; k++) m[k] <<= 1;
      end
      mag = floor_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int k = 0; k < 3; k++) begin
        q = (m[k] * 16384 + mag / 2) / mag;
        res[k] = (s[k] > 0) ? NW'(-q) : NW'(q);
      end
    end
    o.normal_x = res[0];
    o.normal_y = res[1];
    o.normal_z = res[2];
    o.no_faces = 1'b0;
    return o;
  endfunction

  task automatic add_to_sum(int slot, longint cr[3]);
    sum_x[slot] = sat_sum(sum_x[slot], cr[0]);
    sum_y[slot] = sat_sum(sum_y[slot], cr[1]);
    sum_z[slot] = sat_sum(sum_z[slot], cr[2]);
    used[slot] = 1'b1;
  endtask

  task automatic apply_transaction(mvn_pkg::in_t t);
    longint u[3], v[3], cr[3], s[3];
    int a, b, c;
    mvn_pkg::out_t o;
    case (t.operation)
      mvn_pkg::OP_WRITE: begin
        pos_x[t.index] = t.coord_x;
        pos_y[t.index] = t.coord_y;
        pos_z[t.index] = t.coord_z;
        sum_x[t.index] = 0;
        sum_y[t.index] = 0;
        sum_z[t.index] = 0;
        used[t.index] = 1'b0;
      end
      mvn_pkg::OP_FACE: begin
        a = int'(t.corner_a);
        b = int'(t.corner_b);
        c = int'(t.corner_c);
        u[0] = longint'(pos_x[a]) - longint'(pos_x[c]);
        u[1] = longint'(pos_y[a]) - longint'(pos_y[c]);
        u[2] = longint'(pos_z[a]) - longint'(pos_z[c]);
        v[0] = longint'(pos_x[c]) - longint'(pos_x[b]);
        v[1] = longint'(pos_y[c]) - longint'(pos_y[b]);
        v[2] = longint'(pos_z[c]) - longint'(pos_z[b]);
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        add_to_sum(a, cr);
        if (b != a) add_to_sum(b, cr);
        if (c != a && c != b) add_to_sum(c, cr);
      end
      mvn_pkg::OP_READ: begin
        if (used[t.index]) begin
          s[0] = sum_x[t.index];
          s[1] = sum_y[t.index];
          s[2] = sum_z[t.index];
          o = unit_normal(s);
        end else begin
          o = '0;
          o.no_faces = 1'b1;
        end
        normals_due_q.insert(normals_due_q.size(), o);
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(mvn_pkg::in_t t, bit drain = 0, bit rush = 0);
    stim_t e;
    e.item = t;
    e.drain = drain;
    e.rush = rush;
    pending_q.insert(pending_q.size(), e);
  endtask

  task automatic queue_write(int idx, int x, int y, int z, bit drain = 0);
    mvn_pkg::in_t t;
    t = mvn_pkg::in_t'($urandom());
    t.operation = mvn_pkg::OP_WRITE;
    t.index = IW'(idx);
    t.coord_x = CW'(x);
    t.coord_y = CW'(y);
    t.coord_z = CW'(z);
    if (!written[idx]) written_q.insert(written_q.size(), idx);
    written[idx] = 1'b1;
    queue_item(t, drain);
  endtask

  task automatic queue_face(int a, int b, int c, bit rush = 0);
    mvn_pkg::in_t t;
    t = mvn_pkg::in_t'($urandom());
    t.operation = mvn_pkg::OP_FACE;
    t.corner_a = IW'(a);
    t.corner_b = IW'(b);
    t.corner_c = IW'(c);
    queue_item(t, 0, rush);
  endtask

  task automatic queue_read(int idx, bit drain = 0);
    mvn_pkg::in_t t;
    t = mvn_pkg::in_t'({$urandom(), $urandom(), $urandom()});
    t.operation = mvn_pkg::OP_READ;
    t.index = IW'(idx);
    queue_item(t, drain);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: return int'($urandom_range(0, 2047)) - 1024;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_written();
    return written_q[$urandom_range(0, written_q.size() - 1)];
  endfunction

  // driver
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
      in_i.payload <= '0;
    end else begin
      if (in_i.valid && in_i.ready) apply_transaction(in_i.payload);
      if (!in_i.valid || in_i.ready) begin
        if (pending_q.size() == 0) begin
          in_i.valid <= 1'b0;
        end else if (pending_q[0].drain && normals_due_q.size() != 0) begin
          in_i.valid <= 1'b0;
        end else if (gap_left > 0 && !pending_q[0].rush) begin
          gap_left--;
          in_i.valid <= 1'b0;
        end else begin
          in_i.payload <= pending_q[0].item;
          in_i.valid <= 1'b1;
          pending_q[0].drain = 1'b0;
          void'(pending_q.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // monitor
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        if (normals_due_q.size() == 0) begin
          $error("unexpected normal transaction %p", out_o.payload);
          errors++;
        end else begin
          mvn_pkg::out_t e;
          e = normals_due_q.pop_front();
          if (out_o.payload.normal_x !== e.normal_x) begin
            $error("normal_x expected %0d actual %0d", e.normal_x, out_o.payload.normal_x);
            errors++;
          end
          if (out_o.payload.normal_y !== e.normal_y) begin
            $error("normal_y expected %0d actual %0d", e.normal_y, out_o.payload.normal_y);
            errors++;
          end
          if (out_o.payload.normal_z !== e.normal_z) begin
            $error("normal_z expected %0d actual %0d", e.normal_z, out_o.payload.normal_z);
            errors++;
          end
          if (out_o.payload.no_faces !== e.no_faces) begin
            $error("no_faces expected %0d actual %0d", e.no_faces, out_o.payload.no_faces);
            errors++;
          end
        end
      end
      stall_phase = (stall_phase + 1) % 512;
      if (stall_phase < 128) out_o.ready <= 1'b1;
      else if (stall_phase < 320) out_o.ready <= ($urandom_range(0, 2) != 0);
      else out_o.ready <= ($urandom_range(0, 9) == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)
        || (pending_q.size() == 0 && normals_due_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r, idx;
    // directed
    queue_write(0, 32767, -32768, 0);
    queue_write(1023, -32768, 32767, 32767);
    queue_write(1, 0, 0, 0);
    queue_write(2, 256, 0, 0);
    queue_write(3, 0, 256, 0);
    queue_write(5, 0, 0, 0);
    queue_read(1023);
    queue_read(0);
    queue_face(1, 2, 3);
    queue_read(1);
    queue_read(2);
    queue_read(3);
    queue_face(1, 1, 2);
    queue_face(3, 2, 2);
    queue_face(1, 5, 5);
    queue_read(5);
    queue_face(0, 1023, 1);
    queue_read(0);
    queue_read(1023);
    begin
      mvn_pkg::in_t t;
      t = mvn_pkg::in_t'({$urandom(), $urandom(), $urandom()});
      t.operation = OP_SPARE;
      queue_item(t);
    end
    queue_read(1);
    // largest triangle added back to back
    queue_write(10, 32767, -32768, 0, 1);
    queue_write(11, 32767, 32767, 0);
    queue_write(12, -32768, 32767, 0);
    for (int i = 0; i < BIG_FACES; i++) queue_face(10, 11, 12, 1);
    queue_read(10);
    queue_read(11);
    queue_write(10, 1, 2, 3);
    queue_read(10, 1);
    // random
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22 || written_q.size() < 4) begin
        idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 47) : $urandom_range(0, DEPTH - 1);
        queue_write(idx, rand_coord(), rand_coord(), rand_coord(), (i % 500) == 499);
      end else if (r < 70) begin
        queue_face(pick_written(), pick_written(), pick_written());
      end else if (r < 96) begin
        queue_read(pick_written(), (i % 500) == 499);
      end else begin
        mvn_pkg::in_t t;
        t = mvn_pkg::in_t'({$urandom(), $urandom(), $urandom()});
        t.operation = OP_SPARE;
        queue_item(t);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !in_i.valid);
    wait (normals_due_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
